// File: hw/rtl/gsa_pkg.sv
// Package for the generational slot allocator: constants, codes, payload
// and controller/datapath interface types. No dependencies.
`default_nettype none
package gsa_pkg;

  localparam int MaxChunks     = 8;
  localparam int SlotsPerChunk = 64;
  localparam int TotalSlots    = MaxChunks * SlotsPerChunk;
  localparam int ChunkW        = $clog2(MaxChunks);
  localparam int OffW          = $clog2(SlotsPerChunk);
  localparam int AddrW         = $clog2(TotalSlots);
  localparam int OpenW         = ChunkW + 1;
  localparam int FillW         = OffW + 1;
  localparam int CfgW          = 7;
  localparam int IdxW          = 10;
  localparam int GenW          = 8;
  localparam int CntW          = 10;
  localparam int DivSteps      = IdxW;

  localparam logic [GenW-1:0] MaxGeneration = 8'd255;
  localparam logic [CfgW-1:0] CfgReset      = 7'd64;

  localparam logic [1:0] ReqAlloc  = 2'd0;
  localparam logic [1:0] ReqFree   = 2'd1;
  localparam logic [1:0] ReqLookup = 2'd2;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StBad  = 2'd2;

  localparam logic [1:0] KindBad    = 2'd0;
  localparam logic [1:0] KindFull   = 2'd1;
  localparam logic [1:0] KindAlloc  = 2'd2;
  localparam logic [1:0] KindHandle = 2'd3;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [IdxW-1:0] req_index;
    logic [GenW-1:0] req_generation;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [IdxW-1:0] out_index;
    logic [GenW-1:0] out_generation;
  } res_t;

  typedef struct packed {
    logic       clr_step;
    logic       load;
    logic       sel_free;
    logic       sel_new;
    logic       fill_step;
    logic       open_done;
    logic       q_rd;
    logic       s_rd_alloc;
    logic       div_step;
    logic       s_rd_hdl;
    logic       emit;
    logic [1:0] kind;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic fill_last;
    logic div_last;
    logic any_free;
    logic all_open;
    logic hdl_bad;
  } sts_t;

endpackage
`default_nettype wire

// File: hw/rtl/generational_slot_allocator_top.sv
// Top level of the generational slot allocator: controller plus datapath.
// Depends on gsa_pkg, gsa_ctrl, gsa_datapath.
// After reset every slot of the slot store is cleared while busy is high.
// Allocate: select (full: emit), open chunk if needed, queue read, slot read, emit.
// Free/lookup: 10-step serial divide, handle check and slot read (bad: emit), emit.
// Unknown: emit in idle. Result strobe: the cycle after the emit; no output stall.
`default_nettype none
module generational_slot_allocator_top import gsa_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output      logic            busy,
  input  wire req_t            req_i,
  output      res_t            res_o,
  output      logic            res_strobe_o,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i
);

  cmd_t cmd;
  sts_t sts;

  gsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_type_i (req_i.req_type),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  gsa_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .req_i        (req_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .sts_o        (sts),
    .res_o        (res_o),
    .res_strobe_o (res_strobe_o)
  );

endmodule
`default_nettype wire

// File: hw/rtl/gsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module gsa_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// File: hw/rtl/gsa_ctrl.sv
// Allocator controller: sequences clear, allocate, chunk open, divide and
// handle checks. Depends on gsa_pkg.
`default_nettype none
module gsa_ctrl import gsa_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [1:0] req_type_i,
  input  wire sts_t       sts_i,
  output      cmd_t       cmd_o,
  output      logic       busy_o
);

  localparam logic [3:0] SClr  = 4'd0;
  localparam logic [3:0] SIdle = 4'd1;
  localparam logic [3:0] SAsel = 4'd2;
  localparam logic [3:0] SFill = 4'd3;
  localparam logic [3:0] SQrd  = 4'd4;
  localparam logic [3:0] SSrdA = 4'd5;
  localparam logic [3:0] SAwr  = 4'd6;
  localparam logic [3:0] SDiv  = 4'd7;
  localparam logic [3:0] SHrd  = 4'd8;
  localparam logic [3:0] SHfin = 4'd9;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClr;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    busy_o  = (state_q != SIdle);
    case (state_q)
      SClr: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = SIdle;
      end
      SIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          case (req_type_i)
            ReqAlloc:  state_d = SAsel;
            ReqFree:   state_d = SDiv;
            ReqLookup: state_d = SDiv;
            default: begin
              cmd_o.emit = 1'b1;
              cmd_o.kind = KindBad;
            end
          endcase
        end
      end
      SAsel: begin
        if (sts_i.any_free) begin
          cmd_o.sel_free = 1'b1;
          state_d = SQrd;
        end else if (sts_i.all_open) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KindFull;
          state_d = SIdle;
        end else begin
          cmd_o.sel_new = 1'b1;
          state_d = SFill;
        end
      end
      SFill: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.fill_last) begin
          cmd_o.open_done = 1'b1;
          state_d = SQrd;
        end
      end
      SQrd: begin
        cmd_o.q_rd = 1'b1;
        state_d = SSrdA;
      end
      SSrdA: begin
        cmd_o.s_rd_alloc = 1'b1;
        state_d = SAwr;
      end
      SAwr: begin
        cmd_o.emit = 1'b1;
        cmd_o.kind = KindAlloc;
        state_d = SIdle;
      end
      SDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = SHrd;
      end
      SHrd: begin
        if (sts_i.hdl_bad) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KindBad;
          state_d = SIdle;
        end else begin
          cmd_o.s_rd_hdl = 1'b1;
          state_d = SHfin;
        end
      end
      SHfin: begin
        cmd_o.emit = 1'b1;
        cmd_o.kind = KindHandle;
        state_d = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/gsa_datapath.sv
// Allocator datapath: chunk queue pointers, slot and queue RAMs, serial
// divider and result register. Depends on gsa_pkg and gsa_ram.
`default_nettype none
module gsa_datapath import gsa_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cmd_t            cmd_i,
  input  wire req_t            req_i,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i,
  output      sts_t            sts_o,
  output      res_t            res_o,
  output      logic            res_strobe_o
);

  logic [CfgW-1:0]   cfg_q;
  logic [OpenW-1:0]  opened_q;
  logic [OffW-1:0]   front_q [MaxChunks];
  logic [FillW-1:0]  fill_q  [MaxChunks];
  logic [ChunkW-1:0] cur_q;
  logic [CntW-1:0]   cnt_q;
  logic [IdxW-1:0]   num_q;
  logic [CfgW-1:0]   rem_q;
  logic [OffW-1:0]   off_q;
  req_t              req_q;
  res_t              res_q;
  logic              strobe_q;

  logic [CfgW-1:0]   esz;
  logic [MaxChunks-1:0] nonempty;
  logic [ChunkW-1:0] first_c;
  logic [OffW-1:0]   pop_pos, push_pos;
  logic [CfgW-1:0]   div_try;
  logic              div_ge;
  logic              q_we, s_we;
  logic [AddrW-1:0]  q_waddr, q_raddr, s_waddr, s_raddr;
  logic [OffW-1:0]   q_wdata, q_rdata;
  logic [GenW:0]     s_wdata, s_rdata;
  logic [GenW-1:0]   gen_next;
  logic              free_ok, look_ok;
  res_t              res_d;

  always_comb begin
    esz = cfg_q;
    if (cfg_q == '0) esz = CfgW'(1);
    if (cfg_q > CfgW'(SlotsPerChunk)) esz = CfgW'(SlotsPerChunk);
  end

  always_comb begin
    first_c = '0;
    for (int i = MaxChunks - 1; i >= 0; i--) begin
      nonempty[i] = (fill_q[i] != '0) && (OpenW'(i) < opened_q);
      if (nonempty[i]) first_c = ChunkW'(i);
    end
  end

  assign pop_pos  = OffW'(FillW'(front_q[cur_q]) + fill_q[cur_q] - FillW'(1));
  assign push_pos = front_q[cur_q] - OffW'(1);
  assign div_try  = {rem_q[CfgW-2:0], num_q[IdxW-1]};
  assign div_ge   = (div_try >= esz);
  assign gen_next = (s_rdata[GenW-1:0] >= MaxGeneration) ? '0 : s_rdata[GenW-1:0] + GenW'(1);

  assign free_ok = !s_rdata[GenW] && (fill_q[cur_q] < FillW'(SlotsPerChunk));
  assign look_ok = !s_rdata[GenW] && (s_rdata[GenW-1:0] == req_q.req_generation);

  assign sts_o.clr_last  = (cnt_q == CntW'(TotalSlots - 1));
  assign sts_o.fill_last = (cnt_q == CntW'(esz - CfgW'(1)));
  assign sts_o.div_last  = (cnt_q == CntW'(DivSteps - 1));
  assign sts_o.any_free  = |nonempty;
  assign sts_o.all_open  = (opened_q >= OpenW'(MaxChunks));
  assign sts_o.hdl_bad   = (req_q.req_index == '0) || (num_q >= IdxW'(opened_q));

  // queue RAM ports
  always_comb begin
    q_we    = 1'b0;
    q_waddr = {cur_q, cnt_q[OffW-1:0]};
    q_wdata = cnt_q[OffW-1:0];
    if (cmd_i.fill_step) begin
      q_we = 1'b1;
    end else if (cmd_i.emit && cmd_i.kind == KindHandle &&
                 req_q.req_type == ReqFree && free_ok) begin
      q_we    = 1'b1;
      q_waddr = {cur_q, push_pos};
      q_wdata = off_q;
    end
    q_raddr = {cur_q, pop_pos};
  end

  // slot RAM ports: {free, generation}
  always_comb begin
    s_we    = 1'b0;
    s_waddr = {cur_q, off_q};
    s_wdata = {1'b1, s_rdata[GenW-1:0]};
    if (cmd_i.clr_step) begin
      s_we    = 1'b1;
      s_waddr = cnt_q[AddrW-1:0];
      s_wdata = {1'b1, {GenW{1'b0}}};
    end else if (cmd_i.emit && cmd_i.kind == KindAlloc) begin
      s_we    = 1'b1;
      s_wdata = {1'b0, gen_next};
    end else if (cmd_i.emit && cmd_i.kind == KindHandle &&
                 req_q.req_type == ReqFree && free_ok) begin
      s_we = 1'b1;
    end
    if (cmd_i.s_rd_alloc) begin
      s_raddr = {cur_q, q_rdata};
    end else begin
      s_raddr = {num_q[ChunkW-1:0], rem_q[OffW-1:0]};
    end
  end

  gsa_ram #(.Width(OffW), .Depth(TotalSlots)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  gsa_ram #(.Width(GenW + 1), .Depth(TotalSlots)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  always_comb begin
    res_d = '0;
    res_d.status = StBad;
    case (cmd_i.kind)
      KindFull: res_d.status = StFull;
      KindAlloc: begin
        res_d.status         = StOk;
        res_d.out_index      = IdxW'(cur_q) * IdxW'(esz) + IdxW'(off_q) + IdxW'(1);
        res_d.out_generation = gen_next;
      end
      KindHandle: begin
        if ((req_q.req_type == ReqFree) ? free_ok : look_ok) begin
          res_d.status         = StOk;
          res_d.out_index      = req_q.req_index;
          res_d.out_generation = s_rdata[GenW-1:0];
        end
      end
      default: res_d.status = StBad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q    <= CfgReset;
      opened_q <= '0;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
      for (int i = 0; i < MaxChunks; i++) begin
        front_q[i] <= '0;
        fill_q[i]  <= '0;
      end
    end else begin
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      strobe_q <= cmd_i.emit;
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.clr_step || cmd_i.fill_step || cmd_i.div_step) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.open_done) begin
        front_q[cur_q] <= '0;
        fill_q[cur_q]  <= FillW'(esz);
        opened_q       <= opened_q + OpenW'(1);
      end
      if (cmd_i.emit && cmd_i.kind == KindAlloc) begin
        fill_q[cur_q] <= fill_q[cur_q] - FillW'(1);
      end
      if (cmd_i.emit && cmd_i.kind == KindHandle &&
          req_q.req_type == ReqFree && free_ok) begin
        front_q[cur_q] <= push_pos;
        fill_q[cur_q]  <= fill_q[cur_q] + FillW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
      num_q <= req_i.req_index - IdxW'(1);
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      num_q <= {num_q[IdxW-2:0], div_ge};
      rem_q <= div_ge ? div_try - esz : div_try;
    end
    if (cmd_i.sel_free) cur_q <= first_c;
    if (cmd_i.sel_new)  cur_q <= opened_q[ChunkW-1:0];
    if (cmd_i.s_rd_hdl) begin
      cur_q <= num_q[ChunkW-1:0];
      off_q <= rem_q[OffW-1:0];
    end
    if (cmd_i.s_rd_alloc) off_q <= q_rdata;
    if (cmd_i.emit) res_q <= res_d;
  end

  assign res_o        = res_q;
  assign res_strobe_o = strobe_q;

endmodule
`default_nettype wire

// File: hw/rtl/gsa_checker.sv
// Port-level checker for the slot allocator, bound to the top level.
// Depends on gsa_pkg and generational_slot_allocator_top.
`default_nettype none
module gsa_checker import gsa_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire req_t req_i,
  input wire res_t res_o,
  input wire logic res_strobe_o
);

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> (res_o.status == StOk || res_o.status == StFull ||
                      res_o.status == StBad))
    else $error("bad status code");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.status != StOk) |->
      (res_o.out_index == '0 && res_o.out_generation == '0))
    else $error("failed transfer carries a handle");

  a_ok_nonnull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.status == StOk) |-> (res_o.out_index != '0))
    else $error("ok result with null handle");

  a_unknown_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.req_type == 2'd3) |=>
      (res_strobe_o && res_o.status == StBad))
    else $error("unknown request not rejected");

endmodule

bind generational_slot_allocator_top gsa_checker u_gsa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .req_i        (req_i),
  .res_o        (res_o),
  .res_strobe_o (res_strobe_o)
);
`default_nettype wire

// File: test/generational_slot_allocator_top_test.sv
// Testbench for the generational slot allocator top level: drives allocate,
// free and lookup requests and checks every result against a behavioral model.
// Depends on gsa_pkg and generational_slot_allocator_top.
`timescale 1ns / 100ps
`default_nettype none
module generational_slot_allocator_top_test;
  import gsa_pkg::*;

  class slot_ledger;
    logic [GenW-1:0] gen_mem [TotalSlots];
    bit              free_mem [TotalSlots];
    logic [OffW-1:0] offq [TotalSlots];
    int unsigned     qfront [MaxChunks];
    int unsigned     qfill [MaxChunks];
    int unsigned     opened;
    logic [CfgW-1:0] epc;
    res_t            pending [$];
    int unsigned     errors;
    int unsigned     checked;

    function new();
      for (int i = 0; i < TotalSlots; i++) begin
        gen_mem[i] = '0;
        free_mem[i] = 1'b1;
        offq[i] = '0;
      end
      for (int c = 0; c < MaxChunks; c++) begin
        qfront[c] = 0;
        qfill[c] = 0;
      end
      opened = 0;
      epc = CfgReset;
      errors = 0;
      checked = 0;
    endfunction

    function int unsigned chunk_len();
      int unsigned e;
      e = epc;
      if (e == 0) e = 1;
      if (e > SlotsPerChunk) e = SlotsPerChunk;
      return e;
    endfunction

    function bit decode(int unsigned idx, output int unsigned addr);
      int unsigned e;
      int unsigned ch;
      e = chunk_len();
      addr = 0;
      if (idx == 0) return 0;
      ch = (idx - 1) / e;
      if (ch >= opened) return 0;
      addr = ch * SlotsPerChunk + (idx - 1) % e;
      return !free_mem[addr];
    endfunction

    function res_t allocate();
      res_t r;
      int unsigned e, c, base, pos, off, addr;
      e = chunk_len();
      r = '0;
      for (c = 0; c < opened; c++)
        if (qfill[c] != 0) break;
      if (c == opened) begin
        if (opened >= MaxChunks) begin
          r.status = StFull;
          return r;
        end
        base = c * SlotsPerChunk;
        for (int o = 0; o < e; o++) begin
          offq[base + o] = OffW'(o);
          free_mem[base + o] = 1'b1;
        end
        qfront[c] = 0;
        qfill[c] = e;
        opened++;
      end
      base = c * SlotsPerChunk;
      pos = (qfront[c] + qfill[c] - 1) % SlotsPerChunk;
      off = offq[base + pos];
      qfill[c]--;
      addr = base + off;
      free_mem[addr] = 1'b0;
      gen_mem[addr] = (gen_mem[addr] >= MaxGeneration) ? '0 : gen_mem[addr] + GenW'(1);
      r.status = StOk;
      r.out_index = IdxW'(c * e + off + 1);
      r.out_generation = gen_mem[addr];
      return r;
    endfunction

    function res_t release_slot(int unsigned idx);
      res_t r;
      int unsigned addr, c, pos;
      r = '0;
      r.status = StBad;
      if (!decode(idx, addr)) return r;
      c = addr / SlotsPerChunk;
      if (qfill[c] >= SlotsPerChunk) return r;
      pos = (qfront[c] + SlotsPerChunk - 1) % SlotsPerChunk;
      qfront[c] = pos;
      offq[c * SlotsPerChunk + pos] = OffW'(addr % SlotsPerChunk);
      qfill[c]++;
      free_mem[addr] = 1'b1;
      r.status = StOk;
      r.out_index = IdxW'(idx);
      r.out_generation = gen_mem[addr];
      return r;
    endfunction

    function void note_request(req_t q);
      res_t r;
      int unsigned addr;
      r = '0;
      r.status = StBad;
      case (q.req_type)
        ReqAlloc: r = allocate();
        ReqFree: r = release_slot(q.req_index);
        ReqLookup: begin
          if (decode(q.req_index, addr) && gen_mem[addr] == q.req_generation) begin
            r.status = StOk;
            r.out_index = q.req_index;
            r.out_generation = gen_mem[addr];
          end
        end
        default: ;
      endcase
      pending = {pending, r};
    endfunction

    function void check_result(res_t got);
      res_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result status=%0d index=%0d", got.status, got.out_index);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.out_index !== exp.out_index) begin
        $error("out_index: expected %0d, got %0d", exp.out_index, got.out_index);
        errors++;
      end
      if (got.out_generation !== exp.out_generation) begin
        $error("out_generation: expected %0d, got %0d", exp.out_generation,
               got.out_generation);
        errors++;
      end
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  req_t            req_i;
  res_t            res_o;
  logic            res_strobe_o;
  logic            cfg_we_i;
  logic [CfgW-1:0] cfg_wdata_i;

  slot_ledger ledger;
  int unsigned live_handles [$];
  int unsigned burst_left;
  int unsigned n_alloc, n_free, n_lookup;

  generational_slot_allocator_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_o       (res_o),
    .res_strobe_o(res_strobe_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_strobe_o) ledger.check_result(res_o);
  end

  function automatic req_t make_req(logic [1:0] t, int unsigned idx, int unsigned g);
    req_t q;
    q.req_type = t;
    q.req_index = IdxW'(idx);
    q.req_generation = GenW'(g);
    return q;
  endfunction

  task automatic send(req_t q);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
    end
    burst_left--;
    repeat (gap + 1) @(posedge clk_i);
    start <= 1'b1;
    req_i <= q;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    ledger.note_request(q);
    case (q.req_type)
      ReqAlloc: n_alloc++;
      ReqFree: n_free++;
      default: n_lookup++;
    endcase
    start <= 1'b0;
    req_i <= make_req(2'($urandom), $urandom, $urandom);
  endtask

  task automatic drain();
    int unsigned guard;
    guard = 0;
    while (ledger.pending.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (80) @(posedge clk_i);
  endtask

  task automatic set_chunk_len(logic [CfgW-1:0] v);
    int unsigned addr;
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ledger.epc = v;
    // handles that still decode to an allocated slot under the new size
    live_handles.delete();
    for (int i = 1; i <= TotalSlots; i++)
      if (ledger.decode(i, addr)) live_handles = {live_handles, i};
  endtask

  task automatic do_alloc();
    send(make_req(ReqAlloc, $urandom, $urandom));
  endtask

  function automatic int unsigned any_index();
    return $urandom_range(0, 1023);
  endfunction

  task automatic random_phase(int unsigned count);
    req_t q;
    int unsigned k, roll, h, addr;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      k = live_handles.size();
      if (roll < 35 || k == 0) begin
        q = make_req(ReqAlloc, $urandom, $urandom);
      end else if (roll < 60) begin
        h = $urandom_range(0, k - 1);
        q = make_req(ReqFree, live_handles[h], $urandom);
        live_handles.delete(h);
      end else if (roll < 85) begin
        h = live_handles[$urandom_range(0, k - 1)];
        q = make_req(ReqLookup, h, 0);
        if (ledger.decode(h, addr) && $urandom_range(0, 3) != 0)
          q.req_generation = ledger.gen_mem[addr];
        else
          q.req_generation = GenW'($urandom);
      end else begin
        q = make_req(2'($urandom_range(0, 3)), any_index(), $urandom);
      end
      if (q.req_type == ReqAlloc) begin
        send(q);
        if (ledger.pending[$].status == StOk)
          live_handles = {live_handles, int'(ledger.pending[$].out_index)};
      end else begin
        send(q);
      end
    end
  endtask

  initial begin
    ledger = new();
    burst_left = 0;
    n_alloc = 0;
    n_free = 0;
    n_lookup = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: null handle, unknown request, first chunk, wrong generation
    send(make_req(ReqLookup, 0, 0));
    send(make_req(ReqFree, 0, 0));
    send(make_req(2'd3, 1023, 255));
    send(make_req(ReqFree, 1, 0));
    do_alloc();
    do_alloc();
    send(make_req(ReqLookup, 64, 1));
    send(make_req(ReqLookup, 64, 2));
    send(make_req(ReqLookup, 1023, 255));
    send(make_req(ReqFree, 64, 0));
    send(make_req(ReqFree, 64, 0));
    send(make_req(ReqLookup, 64, 1));
    do_alloc();
    send(make_req(ReqLookup, 64, 2));
    send(make_req(ReqFree, 65, 0));

    // chunk size 1: drain chunk 0, open the rest, then full status
    set_chunk_len(7'd1);
    for (int i = 0; i < 72; i++) do_alloc();
    send(make_req(ReqFree, 3, 0));
    do_alloc();
    drain();

    // generation wrap on one slot
    set_chunk_len(7'd0);
    for (int i = 0; i < 255; i++) begin
      send(make_req(ReqFree, 1, 0));
      do_alloc();
    end
    send(make_req(ReqLookup, 1, 8'd0));

    set_chunk_len(7'd127);
    random_phase(40);
    set_chunk_len(7'd3);
    random_phase(40);
    set_chunk_len(7'd64);
    random_phase(40);
    set_chunk_len(7'd17);
    random_phase(40);
    set_chunk_len(7'd100);
    random_phase(40);

    drain();
    $display("Covered %0d allocates, %0d frees, %0d lookups/other; %0d results checked.",
             n_alloc, n_free, n_lookup, ledger.checked);
    $display("Chunk sizes 0, 1, 3, 17, 64, 100, 127 including full and wrap cases.");
    if (ledger.errors == 0 && ledger.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
